// File: rtl/assert_macros.svh
// Assertion macros shared by the SAM time-filter RTL.
// Depends on a clock named clk and a synchronous active-high reset named rst in the user module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/satlf_pkg.sv
// Package for the SAM alignment-time line filter: widths, codes, structs and helpers.
// No dependencies; the parser, the histogram, the top level and the testbench import it.
`timescale 1ns / 1ps

package satlf_pkg;

  localparam int NUM_BUCKETS = 26;
  localparam int BKT_W       = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int CNT_W       = 48;
  localparam int SUM_W       = 64;
  localparam int TIME_W      = 32;
  localparam int MAG_W       = 32;
  localparam int ENTRY_W     = CNT_W + SUM_W;
  localparam int WIN_W       = 31;

  localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [MAG_W-1:0]  MAG_CEIL  = 32'h8000_0000;
  localparam logic [MAG_W-1:0]  TIME_MAX  = 32'h7FFF_FFFF;
  localparam logic [2:0]        TAG_LEN   = 3'd6;

  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_AT    = 8'h40;
  localparam logic [7:0] CHAR_UPA   = 8'h41;
  localparam logic [7:0] CHAR_UPT   = 8'h54;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_LOWI  = 8'h69;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    OP_BYTE     = 2'd0,
    OP_BUCKET   = 2'd1,
    OP_COUNTERS = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_VERDICT  = 2'd0,
    KIND_BUCKET   = 2'd1,
    KIND_COUNTERS = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CLS_HEADER   = 2'd0,
    CLS_KEPT     = 2'd1,
    CLS_EXCLUDED = 2'd2,
    CLS_UNTAGGED = 2'd3
  } class_t;

  typedef enum logic [1:0] {
    PH_SIGN   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef struct packed {
    class_t                    cls;
    logic signed [TIME_W-1:0]  line_time;
    logic [BKT_W-1:0]          bucket;
    logic                      upd;
  } verdict_t;

  typedef struct packed {
    logic [CNT_W-1:0] rec;
    logic [CNT_W-1:0] exc;
  } counters_t;

  typedef struct packed {
    logic             rd_en;
    logic [BKT_W-1:0] rd_addr;
    logic             upd_en;
  } hist_ctrl_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

  // Expected character at each position of the tab-AT:i: tag.
  function automatic logic [7:0] tag_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = CHAR_TAB;
      3'd1:    c = CHAR_UPA;
      3'd2:    c = CHAR_UPT;
      3'd3:    c = CHAR_COLON;
      3'd4:    c = CHAR_LOWI;
      3'd5:    c = CHAR_COLON;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Floor-log2 bucket: times of one or less go to bucket 0, the top bucket takes the rest.
  function automatic logic [BKT_W-1:0] bucket_of(input logic signed [TIME_W-1:0] t);
    logic [4:0] lg;
    logic [BKT_W-1:0] res;
    lg = 5'd0;
    for (int i = 1; i < TIME_W - 1; i++) begin
      if (t[i]) begin
        lg = 5'(i);
      end
    end
    if (t <= 32'sd1) begin
      res = '0;
    end else if (int'(lg) >= NUM_BUCKETS) begin
      res = BKT_W'(NUM_BUCKETS - 1);
    end else begin
      res = lg[BKT_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: rtl/sam_alignment_time_line_filter_core.sv
// Top level of the SAM alignment-time line filter.
// Depends on satlf_pkg, satlf_parser, satlf_hist and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
// The item channel (item_valid / item_stall) carries one transfer per cycle: a text byte
// (operation 0), a histogram bucket readout request (operation 1) or a counter readout
// request (operation 2). Operation 3 is ignored. The result channel (result_valid /
// result_stall) returns one transfer for every newline byte (the line verdict) and for
// every readout; other bytes give no result.
// The path is three registers deep: input register, middle stage (histogram read), and
// result register. The result of an item reaches the result register after the item
// has passed the input register and the middle stage. While the receiver does not stall,
// the block takes one item per cycle; the histogram read-modify-write fits that rate
// because a bucket written in the same cycle that it is read is forwarded.
// When the receiver stalls, the result register holds, the middle stage holds if it has
// a result to pass on, and the input register fills before item_stall is raised.
// Reset clears the line parser, the counters, the histogram valid bits (so every bucket
// reads as zero at once) and sets the window registers to [0, 2147483647].
// The window registers sit at APB addresses 0 (exclude_low) and 4 (exclude_high) and
// are to be written only while the block is idle, which the block does not enforce.

module sam_alignment_time_line_filter_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [1:0]          operation,
  input  logic [7:0]          text_byte,
  input  logic [4:0]          bucket_select,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [1:0]          result_kind,
  output logic [1:0]          line_class,
  output logic signed [31:0]  line_time,
  output logic [47:0]         bucket_count,
  output logic signed [63:0]  bucket_time_sum,
  output logic [47:0]         records_seen,
  output logic [47:0]         records_excluded
);
  import satlf_pkg::*;

  // Window registers.
  logic [WIN_W-1:0] exclude_low;
  logic [WIN_W-1:0] exclude_high;
  logic             cfg_write;

  // Input register.
  logic       s1_valid;
  logic [1:0] s1_op;
  logic [7:0] s1_byte;
  logic [4:0] s1_sel;
  logic       s1_go;
  logic       s1_newline;

  // Middle stage.
  logic                     s2_valid;
  logic                     s2_result;
  kind_t                    s2_kind;
  class_t                   s2_cls;
  logic signed [TIME_W-1:0] s2_time;
  logic                     s2_oob;
  logic                     s2_upd;
  counters_t                s2_cnt;
  logic                     s2_go;

  logic                     item_accept;
  verdict_t                 verdict;
  counters_t                counts;
  hist_ctrl_t               hctrl;
  logic [CNT_W-1:0]         cur_count;
  logic [SUM_W-1:0]         cur_sum;

  // Configuration port: the register is picked by address bit 2 alone.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = paddr[2] ? {1'b0, exclude_high} : {1'b0, exclude_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      exclude_low  <= '0;
      exclude_high <= {WIN_W{1'b1}};
    end else if (cfg_write) begin
      if (paddr[2]) begin
        exclude_high <= pwdata[WIN_W-1:0];
      end else begin
        exclude_low <= pwdata[WIN_W-1:0];
      end
    end
  end

  // Pipeline flow. A middle-stage item without a result may always leave.
  always_comb begin
    s2_go       = s2_valid && (!s2_result || !result_valid || !result_stall);
    s1_go       = s1_valid && (!s2_valid || s2_go);
    item_stall  = s1_valid && !s1_go;
    item_accept = item_valid && !item_stall;
    s1_newline  = (s1_op == OP_BYTE) && (s1_byte == CHAR_NL);
  end

  satlf_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .byte_en      (s1_go && (s1_op == OP_BYTE)),
    .text_byte    (s1_byte),
    .exclude_low  (exclude_low),
    .exclude_high (exclude_high),
    .verdict      (verdict),
    .counts       (counts)
  );

  // At most one histogram read per item: the bucket readout or the bucket to be updated.
  always_comb begin
    hctrl.rd_en   = s1_go && ((s1_op == OP_BUCKET) || (s1_newline && verdict.upd));
    hctrl.rd_addr = (s1_op == OP_BUCKET) ? s1_sel[BKT_W-1:0] : verdict.bucket;
    hctrl.upd_en  = s2_go && s2_upd;
  end

  satlf_hist u_hist (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (hctrl),
    .upd_time  (s2_time),
    .cur_count (cur_count),
    .cur_sum   (cur_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s2_result    <= 1'b0;
      s2_upd       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        s2_valid <= 1'b1;
        unique case (s1_op)
          OP_BYTE:     s2_result <= s1_newline;
          OP_BUCKET:   s2_result <= 1'b1;
          OP_COUNTERS: s2_result <= 1'b1;
          default:     s2_result <= 1'b0;
        endcase
        s2_upd <= s1_newline && verdict.upd;
      end else if (s2_go) begin
        s2_valid  <= 1'b0;
        s2_result <= 1'b0;
        s2_upd    <= 1'b0;
      end
      if (s2_go && s2_result) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers. Fields that do not belong to the result's kind are loaded with zero.
  always_ff @(posedge clk) begin
    if (item_accept) begin
      s1_op   <= operation;
      s1_byte <= text_byte;
      s1_sel  <= bucket_select;
    end
    if (s1_go) begin
      unique case (s1_op)
        OP_BUCKET:   s2_kind <= KIND_BUCKET;
        OP_COUNTERS: s2_kind <= KIND_COUNTERS;
        default:     s2_kind <= KIND_VERDICT;
      endcase
      s2_cls  <= verdict.cls;
      s2_time <= verdict.line_time;
      s2_oob  <= ({1'b0, s1_sel} >= 6'(NUM_BUCKETS));
      s2_cnt  <= counts;
    end
    if (s2_go && s2_result) begin
      result_kind <= s2_kind;
      unique case (s2_kind)
        KIND_VERDICT: begin
          line_class       <= s2_cls;
          line_time        <= s2_time;
          bucket_count     <= '0;
          bucket_time_sum  <= '0;
          records_seen     <= '0;
          records_excluded <= '0;
        end
        KIND_BUCKET: begin
          line_class       <= '0;
          line_time        <= '0;
          bucket_count     <= s2_oob ? '0 : cur_count;
          bucket_time_sum  <= s2_oob ? '0 : cur_sum;
          records_seen     <= '0;
          records_excluded <= '0;
        end
        KIND_COUNTERS: begin
          line_class       <= '0;
          line_time        <= '0;
          bucket_count     <= '0;
          bucket_time_sum  <= '0;
          records_seen     <= s2_cnt.rec;
          records_excluded <= s2_cnt.exc;
        end
        default: begin
          line_class       <= '0;
          line_time        <= '0;
          bucket_count     <= '0;
          bucket_time_sum  <= '0;
          records_seen     <= '0;
          records_excluded <= '0;
        end
      endcase
    end
  end

  `ASSERT_IMPL(a_upd_is_verdict, s2_valid && s2_upd, s2_result && (s2_kind == KIND_VERDICT), "update on a non-verdict")
  `ASSERT_IMPL(a_stall_when_full, item_stall, s1_valid && s2_valid, "input stalled with a free stage")

endmodule

// File: rtl/satlf_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module satlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/satlf_parser.sv
// Per-byte SAM line parser: header detection, tag search, time parsing and line counters.
// Depends on satlf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module satlf_parser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           byte_en,
  input  logic [7:0]                     text_byte,
  input  logic [satlf_pkg::WIN_W-1:0]    exclude_low,
  input  logic [satlf_pkg::WIN_W-1:0]    exclude_high,
  output satlf_pkg::verdict_t            verdict,
  output satlf_pkg::counters_t           counts
);
  import satlf_pkg::*;

  logic             at_line_start, at_line_start_next;
  logic             is_header, is_header_next;
  logic [2:0]       tag_pos, tag_pos_next;
  logic             tag_found, tag_found_next;
  phase_t           phase, phase_next;
  logic             value_neg, value_neg_next;
  logic [MAG_W-1:0] value_mag, value_mag_next;
  logic [CNT_W-1:0] record_count, record_count_next;
  logic [CNT_W-1:0] excluded_count, excluded_count_next;

  logic signed [TIME_W-1:0] cur_time;
  logic                     in_window;
  logic                     line_is_header;

  // Time of the line as it stands now, clamped to the signed 32-bit range.
  always_comb begin
    if (value_neg) begin
      cur_time = -$signed(value_mag);
    end else if (value_mag > TIME_MAX) begin
      cur_time = $signed(TIME_MAX);
    end else begin
      cur_time = $signed(value_mag);
    end
    in_window = (cur_time >= $signed({1'b0, exclude_low}))
             && (cur_time <= $signed({1'b0, exclude_high}));
    line_is_header = !at_line_start && is_header;
  end

  always_comb begin
    verdict.upd       = !line_is_header && tag_found;
    verdict.line_time = verdict.upd ? cur_time : '0;
    verdict.bucket    = bucket_of(cur_time);
    if (line_is_header) begin
      verdict.cls = CLS_HEADER;
    end else if (!tag_found) begin
      verdict.cls = CLS_UNTAGGED;
    end else if (in_window) begin
      verdict.cls = CLS_EXCLUDED;
    end else begin
      verdict.cls = CLS_KEPT;
    end
    counts.rec = record_count;
    counts.exc = excluded_count;
  end

  always_comb begin
    logic hdr;
    logic val;
    logic skip;
    logic dig;
    phase_t ph;
    logic [MAG_W+3:0] m;

    at_line_start_next  = at_line_start;
    is_header_next      = is_header;
    tag_pos_next        = tag_pos;
    tag_found_next      = tag_found;
    phase_next          = phase;
    value_neg_next      = value_neg;
    value_mag_next      = value_mag;
    record_count_next   = record_count;
    excluded_count_next = excluded_count;
    hdr  = is_header;
    val  = 1'b0;
    skip = 1'b0;
    ph   = phase;
    dig  = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
    m    = ({4'b0, value_mag} << 3) + ({4'b0, value_mag} << 1)
         + {MAG_W'(0), text_byte[3:0] - CHAR_ZERO[3:0]};

    if (byte_en) begin
      if (text_byte == CHAR_NL) begin
        if (!line_is_header) begin
          record_count_next = sat_inc(record_count);
          if (tag_found && in_window) begin
            excluded_count_next = sat_inc(excluded_count);
          end
        end
        at_line_start_next = 1'b1;
        is_header_next     = 1'b0;
        tag_pos_next       = '0;
        tag_found_next     = 1'b0;
        phase_next         = PH_SIGN;
        value_neg_next     = 1'b0;
        value_mag_next     = '0;
      end else begin
        if (at_line_start) begin
          hdr = (text_byte == CHAR_AT);
        end
        at_line_start_next = 1'b0;
        is_header_next     = hdr;
        if (!hdr) begin
          if (tag_found) begin
            val = 1'b1;
          end else if (tag_pos >= TAG_LEN) begin
            tag_found_next = 1'b1;
            val            = 1'b1;
          end else if (text_byte == tag_char(tag_pos)) begin
            tag_pos_next = tag_pos + 3'd1;
          end else begin
            tag_pos_next = (text_byte == CHAR_TAB) ? 3'd1 : 3'd0;
          end
          if (val) begin
            if (ph == PH_SIGN) begin
              if (text_byte == CHAR_PLUS || text_byte == CHAR_MINUS) begin
                value_neg_next = (text_byte == CHAR_MINUS);
                phase_next     = PH_DIGITS;
                skip           = 1'b1;
              end else begin
                ph         = dig ? PH_DIGITS : PH_DONE;
                phase_next = ph;
              end
            end
            if (!skip && ph == PH_DIGITS) begin
              if (dig) begin
                value_mag_next = (m > {4'b0, MAG_CEIL}) ? MAG_CEIL : m[MAG_W-1:0];
              end else begin
                phase_next = PH_DONE;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_start  <= 1'b1;
      is_header      <= 1'b0;
      tag_pos        <= '0;
      tag_found      <= 1'b0;
      phase          <= PH_SIGN;
      value_neg      <= 1'b0;
      value_mag      <= '0;
      record_count   <= '0;
      excluded_count <= '0;
    end else begin
      at_line_start  <= at_line_start_next;
      is_header      <= is_header_next;
      tag_pos        <= tag_pos_next;
      tag_found      <= tag_found_next;
      phase          <= phase_next;
      value_neg      <= value_neg_next;
      value_mag      <= value_mag_next;
      record_count   <= record_count_next;
      excluded_count <= excluded_count_next;
    end
  end

  `ASSERT_IMPL(a_tag_pos_range, 1'b1, tag_pos <= TAG_LEN, "tag match position ran past the tag")
  `ASSERT_IMPL(a_mag_ceiling, 1'b1, value_mag <= MAG_CEIL, "time magnitude escaped saturation")

endmodule

// File: rtl/satlf_hist.sv
// Floor-log2 histogram of counts and time sums, held in one RAM with per-entry valid bits.
// Depends on satlf_pkg, satlf_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module satlf_hist (
  input  logic                              clk,
  input  logic                              rst,
  input  satlf_pkg::hist_ctrl_t             ctrl,
  input  logic signed [satlf_pkg::TIME_W-1:0] upd_time,
  output logic [satlf_pkg::CNT_W-1:0]       cur_count,
  output logic [satlf_pkg::SUM_W-1:0]       cur_sum
);
  import satlf_pkg::*;

  logic [NUM_BUCKETS-1:0] vld;
  logic [BKT_W-1:0]       raddr_q;
  logic                   rd_vld;
  logic                   fwd_hit;
  logic [ENTRY_W-1:0]     fwd_data;
  logic [ENTRY_W-1:0]     ram_rdata;
  logic [ENTRY_W-1:0]     cur_entry;
  logic [ENTRY_W-1:0]     wr_data;
  logic                   rd_in_range;

  satlf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_BUCKETS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ctrl.upd_en),
    .wr_addr (raddr_q),
    .wr_data (wr_data),
    .rd_en   (ctrl.rd_en),
    .rd_addr (ctrl.rd_addr),
    .rd_data (ram_rdata)
  );

  // An entry never written reads as zero; a write in the read cycle is forwarded.
  always_comb begin
    if (fwd_hit) begin
      cur_entry = fwd_data;
    end else if (rd_vld) begin
      cur_entry = ram_rdata;
    end else begin
      cur_entry = '0;
    end
    cur_count   = cur_entry[ENTRY_W-1:SUM_W];
    cur_sum     = cur_entry[SUM_W-1:0];
    wr_data     = {sat_inc(cur_count), cur_sum + {{(SUM_W - TIME_W){upd_time[TIME_W-1]}}, upd_time}};
    rd_in_range = ({1'b0, ctrl.rd_addr} < (BKT_W + 1)'(NUM_BUCKETS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      raddr_q <= '0;
      rd_vld  <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      if (ctrl.upd_en) begin
        vld[raddr_q] <= 1'b1;
      end
      if (ctrl.rd_en) begin
        raddr_q <= ctrl.rd_addr;
        rd_vld  <= rd_in_range ? vld[ctrl.rd_addr] : 1'b0;
        fwd_hit <= ctrl.upd_en && (raddr_q == ctrl.rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      fwd_data <= wr_data;
    end
  end

  `ASSERT_NEXT(a_fwd_taken, ctrl.rd_en && ctrl.upd_en && (ctrl.rd_addr == raddr_q), fwd_hit, "write in read cycle was not forwarded")

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the SAM alignment-time line filter core.
// Depends on satlf_pkg and on sam_alignment_time_line_filter_core from the RTL folder.
`timescale 1ns / 1ps

module tb_top;
  import satlf_pkg::*;

  // Operation code that the block must ignore.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Byte addresses of the window registers on the APB port.
  localparam logic [2:0] REG_EXCLUDE_LOW  = 3'd0;
  localparam logic [2:0] REG_EXCLUDE_HIGH = 3'd4;

  // The pipeline is three registers deep, so this wait covers any transfer still in flight.
  localparam int SETTLE_CYCLES  = 12;
  // The longest legitimate quiet spell is a long receiver stall or a long sender gap.
  localparam int WATCHDOG_LIMIT = 2000;

  // The tab-AT:i: tag, first character in the top byte.
  localparam logic [47:0] TIME_TAG = {CHAR_TAB, CHAR_UPA, CHAR_UPT, CHAR_COLON, CHAR_LOWI,
                                      CHAR_COLON};

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
    logic [4:0] sel;
  } stream_item_t;

  typedef struct packed {
    kind_t              kind;
    class_t             cls;
    logic signed [31:0] ltime;
    logic [47:0]        cnt;
    logic signed [63:0] sum;
    logic [47:0]        seen;
    logic [47:0]        excl;
  } report_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                item_valid = 1'b0;
  logic                item_stall;
  logic [1:0]          operation = OP_BYTE;
  logic [7:0]          text_byte = '0;
  logic [4:0]          bucket_select = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [1:0]          result_kind;
  logic [1:0]          line_class;
  logic signed [31:0]  line_time;
  logic [47:0]         bucket_count;
  logic signed [63:0]  bucket_time_sum;
  logic [47:0]         records_seen;
  logic [47:0]         records_excluded;

  sam_alignment_time_line_filter_core dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .operation        (operation),
    .text_byte        (text_byte),
    .bucket_select    (bucket_select),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .result_kind      (result_kind),
    .line_class       (line_class),
    .line_time        (line_time),
    .bucket_count     (bucket_count),
    .bucket_time_sum  (bucket_time_sum),
    .records_seen     (records_seen),
    .records_excluded (records_excluded)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor state: the parser of the current line, the histogram, the line counters and
  // the window. It is advanced once for every item transfer that the block accepts.
  // ---------------------------------------------------------------------------------------
  logic               line_fresh = 1'b1;
  logic               hdr_line = 1'b0;
  logic [2:0]         tag_pos = '0;
  logic               tag_seen = 1'b0;
  phase_t             val_phase = PH_SIGN;
  logic               val_neg = 1'b0;
  logic [31:0]        val_mag = '0;
  logic [47:0]        bin_count [NUM_BUCKETS];
  logic signed [63:0] bin_sum [NUM_BUCKETS];
  logic [47:0]        lines_seen = '0;
  logic [47:0]        lines_excluded = '0;
  logic [30:0]        win_lo = 31'd0;
  logic [30:0]        win_hi = 31'h7FFF_FFFF;

  stream_item_t stream_q [$];
  report_t      due_reports [$];
  int           queued_items = 0;
  int           mism_cnt = 0;
  int           idle_cycles = 0;

  function automatic logic [47:0] bump48(input logic [47:0] v);
    return (v == {48{1'b1}}) ? v : v + 48'd1;
  endfunction

  // Floor of log2 for times above one, capped at the top bin; everything else lands in the lowest bin.
  function automatic int time_bin(input logic signed [63:0] t);
    int lg = 0;
    if (t <= 64'sd1) return 0;
    for (int i = 1; i < 63; i++) begin
      if (t[i]) lg = i;
    end
    return (lg >= NUM_BUCKETS) ? NUM_BUCKETS - 1 : lg;
  endfunction

  // Sign and digits after the tag. Whitespace is not skipped, and the magnitude is held at
  // 2^31 so that the later clamp to the signed 32-bit range stays exact.
  task automatic take_value_char(input logic [7:0] ch);
    logic        is_dig;
    logic [63:0] m;
    is_dig = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    if (val_phase == PH_SIGN && (ch == CHAR_PLUS || ch == CHAR_MINUS)) begin
      val_neg = (ch == CHAR_MINUS);
      val_phase = PH_DIGITS;
    end else begin
      if (val_phase == PH_SIGN) val_phase = is_dig ? PH_DIGITS : PH_DONE;
      if (val_phase == PH_DIGITS) begin
        if (is_dig) begin
          m = {32'd0, val_mag} * 64'd10 + 64'(ch - CHAR_ZERO);
          val_mag = (m > 64'h8000_0000) ? 32'h8000_0000 : m[31:0];
        end else begin
          val_phase = PH_DONE;
        end
      end
    end
  endtask

  task automatic parse_and_classify(input stream_item_t it);
    report_t            rep;
    logic signed [63:0] t;
    int                 k;
    rep = '0;
    if (it.op == OP_BUCKET) begin
      rep.kind = KIND_BUCKET;
      if (it.sel < NUM_BUCKETS) begin
        rep.cnt = bin_count[it.sel];
        rep.sum = bin_sum[it.sel];
      end
      due_reports.push_back(rep);
    end else if (it.op == OP_COUNTERS) begin
      rep.kind = KIND_COUNTERS;
      rep.seen = lines_seen;
      rep.excl = lines_excluded;
      due_reports.push_back(rep);
    end else if (it.op == OP_BYTE && it.ch == CHAR_NL) begin
      rep.kind = KIND_VERDICT;
      if (!line_fresh && hdr_line) begin
        rep.cls = CLS_HEADER;
      end else begin
        // Every non-header line counts, the empty line included.
        lines_seen = bump48(lines_seen);
        if (tag_seen) begin
          t = {32'd0, val_mag};
          if (val_neg) t = -t;
          else if (t > 64'sd2147483647) t = 64'sd2147483647;
          // A window with its low end above its high end contains nothing.
          if (t < $signed({33'd0, win_lo}) || t > $signed({33'd0, win_hi})) begin
            rep.cls = CLS_KEPT;
          end else begin
            rep.cls = CLS_EXCLUDED;
            lines_excluded = bump48(lines_excluded);
          end
          rep.ltime = t[31:0];
          k = time_bin(t);
          bin_count[k] = bump48(bin_count[k]);
          bin_sum[k] = bin_sum[k] + t;
        end else begin
          rep.cls = CLS_UNTAGGED;
        end
      end
      due_reports.push_back(rep);
      line_fresh = 1'b1;
      hdr_line = 1'b0;
      tag_pos = '0;
      tag_seen = 1'b0;
      val_phase = PH_SIGN;
      val_neg = 1'b0;
      val_mag = '0;
    end else if (it.op == OP_BYTE) begin
      if (line_fresh) begin
        line_fresh = 1'b0;
        hdr_line = (it.ch == CHAR_AT);
      end
      if (!hdr_line) begin
        // The tag only counts once a byte follows it on the same line.
        if (tag_seen) begin
          take_value_char(it.ch);
        end else if (tag_pos >= 3'd6) begin
          tag_seen = 1'b1;
          take_value_char(it.ch);
        end else if (it.ch == TIME_TAG[47 - 8 * tag_pos -: 8]) begin
          tag_pos = tag_pos + 3'd1;
        end else begin
          tag_pos = (it.ch == CHAR_TAB) ? 3'd1 : 3'd0;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Sender. It takes items from stream_q, holds a stalled payload steady, and leaves gaps
  // of random length. Now and then it switches to a calm mode in which there are no gaps.
  // ---------------------------------------------------------------------------------------
  int   tx_gap = 0;
  logic tx_calm = 1'b0;

  always @(posedge clk) begin : feed
    stream_item_t it;
    int           r;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        it.op = operation;
        it.ch = text_byte;
        it.sel = bucket_select;
        parse_and_classify(it);
      end
      if (!item_valid || !item_stall) begin
        if (tx_gap != 0) begin
          tx_gap--;
          item_valid <= 1'b0;
        end else if (stream_q.size() != 0) begin
          it = stream_q.pop_front();
          operation <= it.op;
          text_byte <= it.ch;
          bucket_select <= it.sel;
          item_valid <= 1'b1;
          if ($urandom_range(0, 199) == 0) tx_calm = !tx_calm;
          r = $urandom_range(0, 99);
          if (tx_calm || r < 55) tx_gap = 0;
          else if (r < 88) tx_gap = $urandom_range(1, 3);
          else if (r < 98) tx_gap = $urandom_range(4, 12);
          else tx_gap = $urandom_range(20, 60);
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Receiver. Stalls are mostly short with the odd long one, and calm stretches have none.
  // ---------------------------------------------------------------------------------------
  int   stall_left = 0;
  logic rx_calm = 1'b0;

  always @(posedge clk) begin : back_pressure
    int r;
    if (rst) begin
      result_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
      r = $urandom_range(0, 99);
      if (rx_calm || r < 55) begin
        result_stall <= 1'b0;
      end else if (r < 97) begin
        stall_left = $urandom_range(0, 2);
        result_stall <= 1'b1;
      end else begin
        stall_left = $urandom_range(10, 50);
        result_stall <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor and watchdog. Every result transfer is held against the oldest prediction,
  // field by field; fields outside the result's kind must read as zero.
  // ---------------------------------------------------------------------------------------
  function automatic void check_field(input string fname, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, fname, want, got);
      mism_cnt++;
    end
  endfunction

  always @(posedge clk) begin : watch_results
    report_t rep;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (due_reports.size() == 0) begin
          $display("%0t ns: result expected none, got kind %0d", $time, result_kind);
          mism_cnt++;
        end else begin
          rep = due_reports.pop_front();
          check_field("result_kind", rep.kind, result_kind);
          check_field("line_class", rep.cls, line_class);
          check_field("line_time", rep.ltime, line_time);
          check_field("bucket_count", rep.cnt, bucket_count);
          check_field("bucket_time_sum", rep.sum, bucket_time_sum);
          check_field("records_seen", rep.seen, records_seen);
          check_field("records_excluded", rep.excl, records_excluded);
        end
      end
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("sam_alignment_time_line_filter_core: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------------------
  task automatic queue_item(input logic [1:0] op, input logic [7:0] ch,
                            input logic [4:0] sel);
    stream_item_t it;
    it.op = op;
    it.ch = ch;
    it.sel = sel;
    stream_q.push_back(it);
    if (op != OP_UNUSED) queued_items++;
  endtask

  // Unused fields of a byte transfer carry random values so that every input bit toggles.
  task automatic queue_byte(input logic [7:0] ch);
    queue_item(OP_BYTE, ch, 5'($urandom));
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  // Line filler: plenty of tabs and tag characters, so that near misses of the tag are common.
  function automatic logic [7:0] rand_filler();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: c = 8'($urandom_range(32, 126));
      5, 6:          c = CHAR_TAB;
      7:             c = ($urandom_range(0, 1) != 0) ? CHAR_UPA : CHAR_UPT;
      8:             c = ($urandom_range(0, 1) != 0) ? CHAR_LOWI : CHAR_COLON;
      default:       c = 8'($urandom_range(0, 255));
    endcase
    if (c == CHAR_NL) c = CHAR_UPT;
    return c;
  endfunction

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_window(input logic [30:0] lo, input logic [30:0] hi);
    write_reg(REG_EXCLUDE_LOW, {1'b0, lo});
    write_reg(REG_EXCLUDE_HIGH, {1'b0, hi});
    win_lo = lo;
    win_hi = hi;
  endtask

  // Waits until every item has been sent and every result has come back, then lets the
  // pipeline empty out, since plain text bytes leave no result to wait for.
  task automatic wait_idle();
    do @(negedge clk); while (stream_q.size() != 0 || item_valid || due_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly well-formed SAM lines with random content, plus noise, readouts and ignored
  // operations. Some times are aimed at the edges of the current window.
  task automatic stream_random_lines(input int n);
    int                 start, r, len, k;
    logic [31:0]        mag;
    logic signed [63:0] tv;
    start = queued_items;
    while (queued_items - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        // Header, sometimes with a tag in it that must be ignored.
        queue_byte(CHAR_AT);
        len = $urandom_range(0, 10);
        repeat (len) queue_byte(rand_filler());
        if ($urandom_range(0, 3) == 0) queue_text("\tAT:i:7");
        queue_byte(CHAR_NL);
      end else if (r < 65) begin
        len = $urandom_range(0, 8);
        repeat (len) queue_byte(rand_filler());
        queue_text("\tAT:i:");
        r = $urandom_range(0, 99);
        if (r < 80) begin
          if (r < 15) begin
            case ($urandom_range(0, 3))
              0:       tv = $signed({33'd0, win_lo}) - 64'sd1;
              1:       tv = $signed({33'd0, win_lo});
              2:       tv = $signed({33'd0, win_hi});
              default: tv = $signed({33'd0, win_hi}) + 64'sd1;
            endcase
          end else begin
            k = $urandom_range(0, 31);
            mag = (k == 0) ? 32'd0 : ($urandom >> (32 - k));
            tv = {32'd0, mag};
            if ($urandom_range(0, 3) == 0) tv = -tv;
          end
          if (tv < 0) queue_byte(CHAR_MINUS);
          else if ($urandom_range(0, 5) == 0) queue_byte(CHAR_PLUS);
          if ($urandom_range(0, 9) == 0) queue_text("00");
          queue_text($sformatf("%0d", (tv < 0) ? -tv : tv));
        end else if (r < 88) begin
          // Ten to fourteen digits: the time saturates whenever their value leaves the 32-bit range.
          case ($urandom_range(0, 2))
            1:       queue_byte(CHAR_PLUS);
            2:       queue_byte(CHAR_MINUS);
            default: ;
          endcase
          len = $urandom_range(10, 14);
          repeat (len) queue_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
        end else if (r < 93) begin
          // A sign on its own, or nothing at all, gives a time of zero unless filler digits follow.
          case ($urandom_range(0, 2))
            1:       queue_byte(CHAR_PLUS);
            2:       queue_byte(CHAR_MINUS);
            default: ;
          endcase
        end else begin
          // Leading space is not skipped, so the digits after it do not count.
          queue_text(" 42");
        end
        if ($urandom_range(0, 9) < 3) begin
          len = $urandom_range(1, 5);
          repeat (len) queue_byte(rand_filler());
        end
        queue_byte(CHAR_NL);
      end else if (r < 72) begin
        len = $urandom_range(0, 12);
        repeat (len) queue_byte(rand_filler());
        queue_byte(CHAR_NL);
      end else if (r < 75) begin
        queue_byte(CHAR_NL);
      end else if (r < 78) begin
        // Tag with nothing after it before the newline.
        len = $urandom_range(0, 3);
        repeat (len) queue_byte(rand_filler());
        queue_text("\tAT:i:");
        queue_byte(CHAR_NL);
      end else if (r < 85) begin
        len = $urandom_range(1, 20);
        repeat (len) queue_byte(8'($urandom_range(0, 255)));
      end else if (r < 93) begin
        queue_item(OP_BUCKET, 8'($urandom), 5'($urandom_range(0, 31)));
      end else if (r < 97) begin
        queue_item(OP_COUNTERS, 8'($urandom), 5'($urandom));
      end else begin
        queue_item(OP_UNUSED, 8'($urandom), 5'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Test sequence. Each phase runs under its own window; between phases the sender pauses
  // until every result has come back, and only then are the registers rewritten.
  // ---------------------------------------------------------------------------------------
  initial begin
    foreach (bin_count[i]) begin
      bin_count[i] = '0;
      bin_sum[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part under the reset window: an empty line, a header, a tag with nothing
    // after it, a negative time far beyond the 32-bit range, then every readout kind with
    // both extremes of the bucket select and the ignored operation.
    queue_byte(CHAR_NL);
    queue_text("@\n");
    queue_text("\tAT:i:\n");
    queue_text("\tAT:i:-9999999999\n");
    queue_item(OP_BUCKET, 8'h00, 5'd0);
    queue_item(OP_BUCKET, 8'hFF, 5'd31);
    queue_item(OP_COUNTERS, 8'h00, 5'd0);
    queue_item(OP_UNUSED, 8'hFF, 5'd31);
    stream_random_lines(250);
    wait_idle();

    set_window(31'd0, 31'd1);
    stream_random_lines(250);
    wait_idle();

    set_window(31'h7FFF_FFFE, 31'h7FFF_FFFF);
    stream_random_lines(250);
    wait_idle();

    // Low end above high end: nothing is ever excluded.
    set_window(31'd5000, 31'd100);
    stream_random_lines(250);
    wait_idle();

    set_window(31'($urandom_range(0, 1 << 20)), 31'd0);
    set_window(win_lo, 31'(win_lo + $urandom_range(1, 1 << 22)));
    stream_random_lines(250);
    wait_idle();

    set_window(31'd0, 31'h7FFF_FFFF);
    stream_random_lines(250);
    wait_idle();

    if (mism_cnt == 0) begin
      $display("sam_alignment_time_line_filter_core: match");
    end else begin
      $display("sam_alignment_time_line_filter_core: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/satlf_pkg.sv
rtl/satlf_ram.sv
rtl/satlf_parser.sv
rtl/satlf_hist.sv
rtl/sam_alignment_time_line_filter_core.sv
verif/tb_top.sv
